### hdl/rbch_pkg.sv
// ----------------------------------------------------------------------------
// rbch_pkg
// shared widths, codes and word types of the ray/box closest hit core
// ----------------------------------------------------------------------------
package rbch_pkg;

  localparam int COORD_W        = 32;
  localparam int NORM_W         = 18;
  localparam int DIST_W         = 31;
  localparam int COUNT_W        = 7;
  localparam int SLOT_W         = 6;
  localparam int MAX_BOXES_DEF  = 64;
  localparam int IN_W           = 200;
  localparam int OUT_W          = 192;
  localparam int CFG_IDX_W      = 4;
  localparam int CFG_DATA_W     = 32;

  localparam int DIV_RW         = 49;
  localparam int DIV_DW         = 32;
  localparam int DIV_QW         = 32;
  localparam int SQ_IW          = 64;
  localparam int SQ_OW          = 32;

  localparam int MIN_T          = 65;
  localparam logic [DIST_W-1:0] MAXD_RESET = 31'd6553600;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_COUNT    = 4'd1;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_CAST = 1'b1;

  typedef struct packed {
    logic              valid;
    logic [DIV_RW-1:0] rem;
    logic [DIV_DW-1:0] den;
    logic [DIV_QW-1:0] quo;
    logic              ovf;
    logic              neg;
  } div_word_t;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] lo;
    logic [2:0][COORD_W-1:0] hi;
  } box_t;

endpackage

### hdl/rbch_div_cell.sv
// ----------------------------------------------------------------------------
// rbch_div_cell
// one restoring division cell: decides one quotient bit, passes the word on
// ----------------------------------------------------------------------------
module rbch_div_cell #(
  parameter int BIT = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  rbch_pkg::div_word_t din,
  output rbch_pkg::div_word_t dout
);
  import rbch_pkg::*;

  logic [63:0]       shd;
  logic [63:0]       r64;
  logic              ge;
  logic [DIV_QW-1:0] q_next;

  always_comb begin
    shd = 64'(din.den) << BIT;
    r64 = 64'(din.rem);
    ge  = r64 >= shd;
    q_next = din.quo;
    q_next[BIT] = ge;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.rem <= ge ? DIV_RW'(r64 - shd) : din.rem;
    dout.den <= din.den;
    dout.quo <= q_next;
    dout.ovf <= din.ovf;
    dout.neg <= din.neg;
  end

endmodule

### hdl/rbch_div_chain.sv
// ----------------------------------------------------------------------------
// rbch_div_chain
// row of division cells, one quotient bit per cell, a new word every cycle
// ----------------------------------------------------------------------------
module rbch_div_chain (
  input  logic                clk,
  input  logic                rst,
  input  rbch_pkg::div_word_t din,
  output rbch_pkg::div_word_t dout
);
  import rbch_pkg::*;

  div_word_t st [DIV_QW+1];

  // quotient that needs more than the cell count is flagged here
  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].valid <= 1'b0;
    end else begin
      st[0].valid <= din.valid;
    end
    st[0].rem <= din.rem;
    st[0].den <= din.den;
    st[0].quo <= '0;
    st[0].ovf <= 64'(din.rem) >= {din.den, 32'b0};
    st[0].neg <= din.neg;
  end

  for (genvar i = 0; i < DIV_QW; i++) begin : g_cell
    rbch_div_cell #(.BIT(DIV_QW - 1 - i)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (st[i]),
      .dout (st[i+1])
    );
  end

  assign dout = st[DIV_QW];

endmodule

### hdl/rbch_isqrt.sv
// ----------------------------------------------------------------------------
// rbch_isqrt
// floor square root, two radicand bits per cycle
// ----------------------------------------------------------------------------
module rbch_isqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rbch_pkg::SQ_IW-1:0] x,
  output logic                       done,
  output logic [rbch_pkg::SQ_OW-1:0] root
);
  import rbch_pkg::*;

  logic             busy;
  logic [SQ_IW-1:0] xs;
  logic [SQ_OW+1:0] rem;
  logic [4:0]       cnt;
  logic [SQ_OW+3:0] rem2;
  logic [SQ_OW+3:0] trial;
  logic             ge;

  always_comb begin
    rem2  = {rem, xs[SQ_IW-1 -: 2]};
    trial = {2'b00, root, 2'b01};
    ge    = rem2 >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        xs   <= x;
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
      end else if (busy) begin
        xs <= xs << 2;
        if (ge) begin
          rem  <= (SQ_OW+2)'(rem2 - trial);
          root <= {root[SQ_OW-2:0], 1'b1};
        end else begin
          rem  <= (SQ_OW+2)'(rem2);
          root <= {root[SQ_OW-2:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### hdl/ray_box_closest_hit_core.sv
// load word: taken while idle, one per cycle
// cast word: one cast at a time; each tested box takes one table read and six
//   issues into the 33-stage divider chain
// the result word waits in an output register while loads go on
// reset clears control and the output valid flag and puts the two config
//   registers to their reset values; the box table is not cleared
// ----------------------------------------------------------------------------
// ray_box_closest_hit_core
// nearest box hit along a ray: normalize, slab test per box, hit point, normal
// ----------------------------------------------------------------------------
module ray_box_closest_hit_core #(
  parameter int MAX_BOXES = rbch_pkg::MAX_BOXES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // box_slot, vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y, vec_b_z, zero pad
  input  logic [rbch_pkg::IN_W-1:0]       s_tdata,
  // func
  input  logic [0:0]                      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // hit_box, hit_distance, point_x/y/z, normal_x/y/z, zero pad
  output logic [rbch_pkg::OUT_W-1:0]      m_tdata,
  // hit
  output logic [0:0]                      m_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rbch_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbch_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rbch_pkg::*;

  localparam int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW = $clog2(MAX_BOXES + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_NMAG   = 4'd1;
  localparam logic [3:0] S_NSQ    = 4'd2;
  localparam logic [3:0] S_NROOT  = 4'd3;
  localparam logic [3:0] S_NRWAIT = 4'd4;
  localparam logic [3:0] S_NDIV   = 4'd5;
  localparam logic [3:0] S_NWAIT  = 4'd6;
  localparam logic [3:0] S_NFIN   = 4'd7;
  localparam logic [3:0] S_BREAD  = 4'd8;
  localparam logic [3:0] S_BISSUE = 4'd9;
  localparam logic [3:0] S_BWAIT  = 4'd10;
  localparam logic [3:0] S_PREAD  = 4'd11;
  localparam logic [3:0] S_PMUL   = 4'd12;
  localparam logic [3:0] S_PSUM   = 4'd13;
  localparam logic [3:0] S_DONE   = 4'd14;

  logic [3:0]                state;
  logic [DIST_W-1:0]         max_distance;
  logic [COUNT_W-1:0]        box_count;

  box_t                      mem [MAX_BOXES];
  box_t                      rd;
  box_t                      wbox;
  logic                      rd_en;
  logic [IW-1:0]             raddr;
  logic                      wr_en;

  logic signed [COORD_W-1:0] org  [3];
  logic signed [NORM_W-1:0]  dvec [3];
  logic signed [33:0]        vin  [3];
  logic                      vneg [3];
  logic [30:0]               mg   [3];
  logic [61:0]               sq;
  logic [63:0]               sum;
  logic [2:0]                cnt;
  logic [31:0]               len;
  logic [16:0]               nres [3];
  logic [1:0]                rcnt;
  logic                      nphase;
  logic                      slab_mode;

  logic [CW-1:0]             ibox;
  logic [CW-1:0]             rbox;
  logic [CW-1:0]             ncnt;
  logic [2:0]                ij;
  logic [2:0]                rj;
  logic signed [31:0]        t0r;
  logic signed [31:0]        tmin;
  logic signed [31:0]        tmax;
  logic                      chk;
  logic                      hit;
  logic [IW-1:0]             idx;
  logic [DIST_W-1:0]         best;
  logic signed [49:0]        pprod;
  logic signed [COORD_W-1:0] pt   [3];
  logic signed [NORM_W-1:0]  nvec [3];

  logic                      out_valid;
  logic                      o_hit;
  logic [SLOT_W-1:0]         o_box;
  logic [DIST_W-1:0]         o_dist;
  logic signed [COORD_W-1:0] o_pt [3];
  logic signed [NORM_W-1:0]  o_nv [3];

  div_word_t                 div_in;
  div_word_t                 div_out;
  logic                      sq_done;
  logic [SQ_OW-1:0]          sq_root;

  logic [33:0]               mag  [3];
  logic [33:0]               msh  [3];
  logic [33:0]               mx;
  logic [1:0]                shamt;
  logic signed [NORM_W-1:0]  nvn  [3];
  logic [1:0]                ki;
  logic [COORD_W-1:0]        bound;
  logic signed [32:0]        diff;
  logic [32:0]               adiff;
  logic [NORM_W-1:0]         dabs;
  logic signed [31:0]        tres;
  logic [1:0]                ko;
  logic signed [31:0]        lo_t;
  logic signed [31:0]        hi_t;
  logic signed [31:0]        bmin;
  logic signed [31:0]        bmax;
  logic [1:0]                pidx;
  logic signed [34:0]        psum;
  logic signed [COORD_W-1:0] psat;
  logic signed [32:0]        ctr  [3];
  logic signed [33:0]        rel  [3];

  function automatic logic signed [31:0] slab_sat(input logic [DIV_QW-1:0] q,
                                                  input logic ovf, input logic neg);
    logic signed [31:0] r;
    if (!neg) begin
      r = (ovf || q[31]) ? 32'sh7fffffff : $signed(q);
    end else begin
      r = (ovf || (q[31] && (q[30:0] != 31'd0))) ? 32'sh80000000 : $signed(-q);
    end
    return r;
  endfunction

  rbch_div_chain u_div (
    .clk  (clk),
    .rst  (rst),
    .din  (div_in),
    .dout (div_out)
  );

  rbch_isqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_NROOT),
    .x     (sum),
    .done  (sq_done),
    .root  (sq_root)
  );

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tuser   = o_hit;
  assign m_tdata   = {5'b0, o_nv[2], o_nv[1], o_nv[0], o_pt[2], o_pt[1], o_pt[0],
                      o_dist, o_box};

  // box table
  always_comb begin
    wbox.lo = {s_tdata[101:70], s_tdata[69:38], s_tdata[37:6]};
    wbox.hi = {s_tdata[197:166], s_tdata[165:134], s_tdata[133:102]};
    wr_en   = s_tvalid && s_tready && (s_tuser[0] == FUNC_LOAD) &&
              (32'(s_tdata[5:0]) < MAX_BOXES);
    rd_en   = (state == S_BREAD) || (state == S_PREAD);
    raddr   = (state == S_PREAD) ? idx : ibox[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[IW'(s_tdata[5:0])] <= wbox;
    end
    if (rd_en) begin
      rd <= mem[raddr];
    end
  end

  always_comb begin
    ncnt = (32'(box_count) > MAX_BOXES) ? CW'(MAX_BOXES) : CW'(box_count);

    for (int k = 0; k < 3; k++) begin
      mag[k] = vin[k][33] ? 34'(-vin[k]) : 34'(vin[k]);
      nvn[k] = vneg[k] ? -$signed({1'b0, nres[k]}) : $signed({1'b0, nres[k]});
    end
    mx = mag[0];
    if (mag[1] > mx) mx = mag[1];
    if (mag[2] > mx) mx = mag[2];
    shamt = (mx[33] || mx[32]) ? 2'd2 : (mx[31] ? 2'd1 : 2'd0);
    for (int k = 0; k < 3; k++) begin
      msh[k] = mag[k] >> shamt;
    end

    // slab issue
    ki    = ij[2:1];
    bound = ij[0] ? rd.hi[ki] : rd.lo[ki];
    diff  = $signed({bound[COORD_W-1], bound}) - $signed({org[ki][COORD_W-1], org[ki]});
    adiff = diff[32] ? 33'(-diff) : 33'(diff);
    dabs  = dvec[ki][NORM_W-1] ? NORM_W'(-dvec[ki]) : NORM_W'(dvec[ki]);

    div_in.valid = (state == S_BISSUE) || (state == S_NDIV);
    div_in.quo   = '0;
    div_in.ovf   = 1'b0;
    if (state == S_BISSUE) begin
      div_in.rem = {adiff, 16'b0};
      div_in.den = DIV_DW'(dabs);
      div_in.neg = diff[32] ^ dvec[ki][NORM_W-1];
    end else begin
      div_in.rem = DIV_RW'({mg[cnt[1:0]], 16'b0});
      div_in.den = len;
      div_in.neg = 1'b0;
    end

    // slab result
    tres = slab_sat(div_out.quo, div_out.ovf, div_out.neg);
    ko   = rj[2:1];
    lo_t = dvec[ko][NORM_W-1] ? tres : t0r;
    hi_t = dvec[ko][NORM_W-1] ? t0r : tres;
    bmin = (ko == 2'd0) ? 32'sd0 : tmin;
    bmax = (ko == 2'd0) ? $signed({1'b0, max_distance}) : tmax;

    // hit point
    pidx = cnt[1:0] - 2'd1;
    psum = 35'(org[pidx]) + 35'($signed(pprod[49:16]));
    if (psum > 35'sd2147483647) begin
      psat = 32'sh7fffffff;
    end else if (psum < -35'sd2147483648) begin
      psat = 32'sh80000000;
    end else begin
      psat = psum[31:0];
    end

    for (int k = 0; k < 3; k++) begin
      ctr[k] = ($signed({rd.lo[k][COORD_W-1], rd.lo[k]}) +
                $signed({rd.hi[k][COORD_W-1], rd.hi[k]})) >>> 1;
      rel[k] = 34'(pt[k]) - 34'(ctr[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      max_distance <= MAXD_RESET;
      box_count    <= '0;
      slab_mode    <= 1'b0;
      chk          <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_MAX_DISTANCE: max_distance <= cfg_data[DIST_W-1:0];
          CFG_BOX_COUNT:    box_count    <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end

      if (div_out.valid) begin
        if (!slab_mode) begin
          nres[rcnt] <= div_out.quo[16:0];
          rcnt       <= rcnt + 2'd1;
        end else begin
          if (!rj[0]) begin
            t0r <= tres;
          end else begin
            tmin <= (lo_t > bmin) ? lo_t : bmin;
            tmax <= (hi_t < bmax) ? hi_t : bmax;
          end
          if (rj == 3'd5) begin
            rj  <= '0;
            chk <= 1'b1;
          end else begin
            rj <= rj + 3'd1;
          end
        end
      end

      if (chk) begin
        chk  <= 1'b0;
        rbox <= rbox + CW'(1);
        if ((tmax > tmin) && (tmin > MIN_T) && (tmin < $signed({1'b0, best}))) begin
          hit  <= 1'b1;
          best <= tmin[DIST_W-1:0];
          idx  <= rbox[IW-1:0];
        end
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid && (s_tuser[0] == FUNC_CAST)) begin
            org[0] <= s_tdata[37:6];
            org[1] <= s_tdata[69:38];
            org[2] <= s_tdata[101:70];
            vin[0] <= 34'($signed(s_tdata[133:102]));
            vin[1] <= 34'($signed(s_tdata[165:134]));
            vin[2] <= 34'($signed(s_tdata[197:166]));
            nphase <= 1'b0;
            state  <= S_NMAG;
          end
        end
        S_NMAG: begin
          for (int k = 0; k < 3; k++) begin
            vneg[k] <= vin[k][33];
            mg[k]   <= msh[k][30:0];
          end
          sum   <= '0;
          cnt   <= '0;
          state <= S_NSQ;
        end
        S_NSQ: begin
          if (cnt != 3'd3) sq <= mg[cnt[1:0]] * mg[cnt[1:0]];
          if (cnt != 3'd0) sum <= sum + 64'(sq);
          if (cnt == 3'd3) state <= S_NROOT;
          cnt <= cnt + 3'd1;
        end
        S_NROOT: begin
          state <= S_NRWAIT;
        end
        S_NRWAIT: begin
          if (sq_done) begin
            len  <= sq_root;
            cnt  <= '0;
            rcnt <= '0;
            if (sq_root == '0) begin
              for (int k = 0; k < 3; k++) nres[k] <= '0;
              state <= S_NFIN;
            end else begin
              state <= S_NDIV;
            end
          end
        end
        S_NDIV: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd2) state <= S_NWAIT;
        end
        S_NWAIT: begin
          if (rcnt == 2'd3) state <= S_NFIN;
        end
        S_NFIN: begin
          if (!nphase) begin
            for (int k = 0; k < 3; k++) begin
              dvec[k] <= (nvn[k] == '0) ? 18'sd1 : nvn[k];
            end
            ibox      <= '0;
            rbox      <= '0;
            ij        <= '0;
            rj        <= '0;
            best      <= max_distance;
            hit       <= 1'b0;
            idx       <= '0;
            slab_mode <= 1'b1;
            state     <= (ncnt == '0) ? S_BWAIT : S_BREAD;
          end else begin
            for (int k = 0; k < 3; k++) nvec[k] <= nvn[k];
            state <= S_DONE;
          end
        end
        S_BREAD: begin
          ij    <= '0;
          state <= S_BISSUE;
        end
        S_BISSUE: begin
          if (ij == 3'd5) begin
            ij    <= '0;
            ibox  <= ibox + CW'(1);
            state <= (CW'(ibox + CW'(1)) == ncnt) ? S_BWAIT : S_BREAD;
          end else begin
            ij <= ij + 3'd1;
          end
        end
        S_BWAIT: begin
          if ((rbox == ncnt) && !chk && !div_out.valid) begin
            slab_mode <= 1'b0;
            if (hit) begin
              state <= S_PREAD;
            end else begin
              for (int k = 0; k < 3; k++) begin
                pt[k]   <= '0;
                nvec[k] <= '0;
              end
              state <= S_DONE;
            end
          end
        end
        S_PREAD: begin
          cnt   <= '0;
          state <= S_PMUL;
        end
        S_PMUL: begin
          if (cnt != 3'd3) pprod <= dvec[cnt[1:0]] * $signed({1'b0, best});
          if (cnt != 3'd0) pt[pidx] <= psat;
          if (cnt == 3'd3) state <= S_PSUM;
          cnt <= cnt + 3'd1;
        end
        S_PSUM: begin
          for (int k = 0; k < 3; k++) vin[k] <= rel[k];
          nphase <= 1'b1;
          state  <= S_NMAG;
        end
        S_DONE: begin
          if (!out_valid) begin
            o_hit  <= hit;
            o_box  <= SLOT_W'(idx);
            o_dist <= best;
            for (int k = 0; k < 3; k++) begin
              o_pt[k] <= pt[k];
              o_nv[k] <= nvec[k];
            end
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/rbch_checker.sv
// ----------------------------------------------------------------------------
// rbch_checker
// port-level checks on the result channel of the closest hit core
// ----------------------------------------------------------------------------
module rbch_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [rbch_pkg::OUT_W-1:0] m_tdata,
  input logic [0:0]                m_tuser
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result word changed");

  // a miss carries slot, point and normal as zero
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> (m_tdata[5:0] == 6'd0) && (m_tdata[186:37] == '0))
    else $error("miss word with nonzero fields");

  // a hit lies beyond the near limit
  a_hit_far: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[36:6] > 31'd65)
    else $error("hit distance inside near limit");

endmodule

bind ray_box_closest_hit_core rbch_checker u_rbch_checker (.*);
